>>> src/robi_pkg.sv
// Shared widths, types and helper function of the ray versus oriented box block.
`default_nettype none
package robi_pkg;

    localparam int CW       = 32;
    localparam int CFG_DW   = (CW > 32) ? CW : 32;
    localparam int CFG_IW   = 4;
    localparam int HW       = 31;
    localparam int QCW      = 16;
    localparam int MW       = 35;
    localparam int PW       = CW + 1;
    localparam int SPLIT    = 16;
    localparam int HIW      = PW - SPLIT;
    localparam int LOW      = SPLIT + 1;
    localparam int PRW      = MW + HIW;
    localparam int PLW      = MW + LOW;
    localparam int SHW      = PRW + 2;
    localparam int SLW      = PLW + 2;
    localparam int SUMW     = ((SHW + SPLIT > SLW) ? SHW + SPLIT : SLW) + 1;
    localparam int MSHIFT   = 28;
    localparam int LOCW     = 46;
    localparam int NW       = LOCW + 1;
    localparam int NAW      = LOCW;
    localparam int DAW      = LOCW - 1;
    localparam int FRAC     = 16;
    localparam int NUMW     = NAW + FRAC;
    localparam int TW       = 64;
    localparam int ROT_LAT  = 3;
    localparam int LAT      = 1 + ROT_LAT + 2 + NUMW + 3;
    localparam int IN_DW    = 6 * CW;
    localparam int OUT_DW   = ((CW + 1 + 7) / 8) * 8;

    localparam logic signed [MW-1:0]   M_ONE   = MW'(1) << MSHIFT;
    localparam logic signed [LOCW-1:0] LOC_LIM = {1'b0, {(LOCW-1){1'b1}}};
    localparam logic signed [TW-1:0]   T_INF   = {1'b0, {(TW-1){1'b1}}};
    localparam logic signed [TW-1:0]   TE_MAX  = {{(TW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [TW-1:0]   TE_MIN  = -TE_MAX - TW'(1);

    typedef enum logic [CFG_IW-1:0] {
        REG_CENTER_X = 4'd0,
        REG_CENTER_Y = 4'd1,
        REG_CENTER_Z = 4'd2,
        REG_HALF_X   = 4'd3,
        REG_HALF_Y   = 4'd4,
        REG_HALF_Z   = 4'd5,
        REG_ROT_WX   = 4'd6,
        REG_ROT_YZ   = 4'd7
    } t_reg_idx;

    typedef logic signed [PW-1:0]   t_pv;
    typedef logic signed [LOCW-1:0] t_loc;

    typedef struct packed {
        logic zero;
        logic above;
        logic below;
        logic neg1;
        logic neg2;
    } t_slab_tag;

    typedef struct packed {
        logic [DAW-1:0]  rem1;
        logic [DAW-1:0]  rem2;
        logic [NUMW-1:0] q1;
        logic [NUMW-1:0] q2;
        logic [NUMW-1:0] n1;
        logic [NUMW-1:0] n2;
        logic [DAW-1:0]  d;
        t_slab_tag       tag;
    } t_div_st;

    function automatic t_div_st div_step(t_div_st s);
        logic [DAW:0] tr1;
        logic [DAW:0] tr2;
        t_div_st      o;
        o   = s;
        tr1 = {s.rem1, s.n1[NUMW-1]};
        tr2 = {s.rem2, s.n2[NUMW-1]};
        if (tr1 >= {1'b0, s.d}) begin
            o.rem1 = DAW'(tr1 - {1'b0, s.d});
            o.q1   = {s.q1[NUMW-2:0], 1'b1};
        end else begin
            o.rem1 = tr1[DAW-1:0];
            o.q1   = {s.q1[NUMW-2:0], 1'b0};
        end
        if (tr2 >= {1'b0, s.d}) begin
            o.rem2 = DAW'(tr2 - {1'b0, s.d});
            o.q2   = {s.q2[NUMW-2:0], 1'b1};
        end else begin
            o.rem2 = tr2[DAW-1:0];
            o.q2   = {s.q2[NUMW-2:0], 1'b0};
        end
        o.n1 = {s.n1[NUMW-2:0], 1'b0};
        o.n2 = {s.n2[NUMW-2:0], 1'b0};
        return o;
    endfunction

endpackage
`default_nettype wire

>>> src/robi_rotate.sv
// Rotation matrix from the quaternion and the three-stage inverse rotation of origin and direction.
`default_nettype none
module robi_rotate (
    input  wire logic           i_clk,
    input  wire logic           i_en,
    input  wire logic [31:0]    i_rot_wx,
    input  wire logic [31:0]    i_rot_yz,
    input  wire robi_pkg::t_pv  i_v   [2][3],
    output robi_pkg::t_loc      o_loc [2][3]
);
    import robi_pkg::*;

    logic signed [QCW-1:0] w_qw, w_qx, w_qy, w_qz;
    logic signed [31:0]    w_xx, w_yy, w_zz, w_xy, w_xz, w_yz, w_wx, w_wy, w_wz;
    logic signed [MW-1:0]  n_m [3][3];
    logic signed [MW-1:0]  r_m [3][3];

    logic signed [PRW-1:0] n_ph [2][3][3];
    logic signed [PLW-1:0] n_pl [2][3][3];
    logic signed [PRW-1:0] r_ph [2][3][3];
    logic signed [PLW-1:0] r_pl [2][3][3];
    logic signed [SHW-1:0] n_sh [2][3];
    logic signed [SLW-1:0] n_sl [2][3];
    logic signed [SHW-1:0] r_sh [2][3];
    logic signed [SLW-1:0] r_sl [2][3];
    t_loc                  n_loc [2][3];
    t_loc                  r_loc [2][3];

    assign w_qw = i_rot_wx[31:16];
    assign w_qx = i_rot_wx[15:0];
    assign w_qy = i_rot_yz[31:16];
    assign w_qz = i_rot_yz[15:0];
    assign w_xx = w_qx * w_qx;
    assign w_yy = w_qy * w_qy;
    assign w_zz = w_qz * w_qz;
    assign w_xy = w_qx * w_qy;
    assign w_xz = w_qx * w_qz;
    assign w_yz = w_qy * w_qz;
    assign w_wx = w_qw * w_qx;
    assign w_wy = w_qw * w_qy;
    assign w_wz = w_qw * w_qz;

    always_comb begin
        n_m[0][0] = M_ONE - ((MW'(w_yy) + MW'(w_zz)) <<< 1);
        n_m[0][1] = (MW'(w_xy) - MW'(w_wz)) <<< 1;
        n_m[0][2] = (MW'(w_xz) + MW'(w_wy)) <<< 1;
        n_m[1][0] = (MW'(w_xy) + MW'(w_wz)) <<< 1;
        n_m[1][1] = M_ONE - ((MW'(w_xx) + MW'(w_zz)) <<< 1);
        n_m[1][2] = (MW'(w_yz) - MW'(w_wx)) <<< 1;
        n_m[2][0] = (MW'(w_xz) - MW'(w_wy)) <<< 1;
        n_m[2][1] = (MW'(w_yz) + MW'(w_wx)) <<< 1;
        n_m[2][2] = M_ONE - ((MW'(w_xx) + MW'(w_yy)) <<< 1);
    end

    always_ff @(posedge i_clk) begin
        r_m <= n_m;
    end

    always_comb begin
        logic signed [HIW-1:0] hi;
        logic signed [LOW-1:0] lo;
        for (int v = 0; v < 2; v++) begin
            for (int j = 0; j < 3; j++) begin
                hi = i_v[v][j][PW-1:SPLIT];
                lo = {1'b0, i_v[v][j][SPLIT-1:0]};
                for (int i = 0; i < 3; i++) begin
                    n_ph[v][j][i] = PRW'(r_m[j][i]) * PRW'(hi);
                    n_pl[v][j][i] = PLW'(r_m[j][i]) * PLW'(lo);
                end
            end
        end
    end

    always_comb begin
        for (int v = 0; v < 2; v++) begin
            for (int i = 0; i < 3; i++) begin
                n_sh[v][i] = SHW'(r_ph[v][0][i]) + SHW'(r_ph[v][1][i]) + SHW'(r_ph[v][2][i]);
                n_sl[v][i] = SLW'(r_pl[v][0][i]) + SLW'(r_pl[v][1][i]) + SLW'(r_pl[v][2][i]);
            end
        end
    end

    always_comb begin
        logic signed [SUMW-1:0] full;
        logic signed [SUMW-1:0] sft;
        for (int v = 0; v < 2; v++) begin
            for (int i = 0; i < 3; i++) begin
                full = (SUMW'(r_sh[v][i]) <<< SPLIT) + SUMW'(r_sl[v][i]);
                sft  = full >>> MSHIFT;
                if (sft > SUMW'(LOC_LIM)) begin
                    n_loc[v][i] = LOC_LIM;
                end else if (sft < -SUMW'(LOC_LIM)) begin
                    n_loc[v][i] = -LOC_LIM;
                end else begin
                    n_loc[v][i] = sft[LOCW-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ph  <= n_ph;
            r_pl  <= n_pl;
            r_sh  <= n_sh;
            r_sl  <= n_sl;
            r_loc <= n_loc;
        end
    end

    assign o_loc = r_loc;

endmodule
`default_nettype wire

>>> src/robi_div.sv
// Pipelined restoring divider: two numerators over one divisor, one quotient bit per stage.
`default_nettype none
module robi_div (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire robi_pkg::t_div_st i_st,
    output robi_pkg::t_div_st      o_st
);
    import robi_pkg::*;

    t_div_st w_in [NUMW];
    t_div_st r_st [NUMW];

    assign w_in[0] = i_st;

    for (genvar k = 0; k < NUMW; k++) begin : g_stage
        if (k > 0) begin : g_link
            assign w_in[k] = r_st[k-1];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[k] <= div_step(w_in[k]);
            end
        end
    end

    assign o_st = r_st[NUMW-1];

endmodule
`default_nettype wire

>>> src/ray_oriented_box_intersect.sv
// Top level of the ray versus oriented box slab test.
//
// Slave stream: one ray per transfer, tdata holds orig_x, orig_y, orig_z, dir_x,
// dir_y, dir_z (32 bits each, signed Q16.16, orig_x lowest).
// Master stream: one result per ray, tdata holds hit (bit 0) and t_entry (bits 32:1).
// Configuration: i_cfg_valid/o_cfg_ready with a register index and data; ready is
// always high, indexes above 7 are ignored. Write only while no ray is in flight.
// Pipeline from input transfer to o_m_tvalid: one input stage, three
// rotation stages, two numerator stages, 62 divider stages (one quotient bit each),
// three compare stages and the output register.
// Throughput: one ray per cycle while o_s_tready is high, set by the fully pipelined divider.
// Reset clears all valid bits and loads the default box (unit half extents at the
// origin, identity rotation).
// A stalled receiver holds the output; one more result drains into a skid
// register, then the whole pipeline freezes and o_s_tready drops.
`default_nettype none
module ray_oriented_box_intersect (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    // orig_x, orig_y, orig_z, dir_x, dir_y, dir_z
    input  wire logic [robi_pkg::IN_DW-1:0]    i_s_tdata,
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // hit, t_entry, zero fill
    output logic [robi_pkg::OUT_DW-1:0]        o_m_tdata,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [robi_pkg::CFG_IW-1:0]   i_cfg_index,
    input  wire logic [robi_pkg::CFG_DW-1:0]   i_cfg_data
);
    import robi_pkg::*;

    logic signed [CW-1:0] r_center [3];
    logic [HW-1:0]        r_half   [3];
    logic [31:0]          r_rot_wx;
    logic [31:0]          r_rot_yz;

    logic                 w_en;
    logic [LAT-1:0]       r_vld;
    logic signed [CW-1:0] w_orig [3];
    logic signed [CW-1:0] w_dir  [3];
    t_pv                  r_v    [2][3];
    t_loc                 w_loc  [2][3];

    logic signed [NW-1:0]   n_n1 [3], n_n2 [3], r_n1 [3], r_n2 [3];
    t_loc                   r_d5 [3];
    t_slab_tag              n_tag5 [3], r_tag5 [3];
    t_div_st                n_dv [3], r_dv [3], w_dq [3];
    logic signed [TW-1:0]   n_t1 [3], n_t2 [3], r_t1 [3], r_t2 [3];
    t_slab_tag              r_tagf [3];
    logic signed [TW-1:0]   n_sm [3], n_bg [3], r_sm [3], r_bg [3];
    logic signed [TW-1:0]   n_tmin, n_tmax, r_tmin, r_tmax;
    logic                   w_hit;
    logic [CW-1:0]          w_entry;
    logic [OUT_DW-1:0]      w_res;
    logic [OUT_DW-1:0]      r_out, r_skid;
    logic                   r_out_v, r_skid_v;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center[0] <= '0;
            r_center[1] <= '0;
            r_center[2] <= '0;
            r_half[0]   <= HW'(65536);
            r_half[1]   <= HW'(65536);
            r_half[2]   <= HW'(65536);
            r_rot_wx    <= 32'h4000_0000;
            r_rot_yz    <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_CENTER_X: r_center[0] <= i_cfg_data[CW-1:0];
                REG_CENTER_Y: r_center[1] <= i_cfg_data[CW-1:0];
                REG_CENTER_Z: r_center[2] <= i_cfg_data[CW-1:0];
                REG_HALF_X:   r_half[0]   <= i_cfg_data[HW-1:0];
                REG_HALF_Y:   r_half[1]   <= i_cfg_data[HW-1:0];
                REG_HALF_Z:   r_half[2]   <= i_cfg_data[HW-1:0];
                REG_ROT_WX:   r_rot_wx    <= i_cfg_data[31:0];
                REG_ROT_YZ:   r_rot_yz    <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    assign w_en       = !r_skid_v;
    assign o_s_tready = w_en;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_orig[a] = i_s_tdata[a*CW +: CW];
            w_dir[a]  = i_s_tdata[(a+3)*CW +: CW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int a = 0; a < 3; a++) begin
                r_v[0][a] <= PW'(w_orig[a]) - PW'(r_center[a]);
                r_v[1][a] <= PW'(w_dir[a]);
            end
        end
    end

    robi_rotate u_rotate (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_rot_wx (r_rot_wx),
        .i_rot_yz (r_rot_yz),
        .i_v      (r_v),
        .o_loc    (w_loc)
    );

    always_comb begin
        t_loc hs;
        t_loc lo;
        for (int a = 0; a < 3; a++) begin
            hs = $signed({{(LOCW-HW){1'b0}}, r_half[a]});
            lo = w_loc[0][a];
            n_n1[a] = -NW'(hs) - NW'(lo);
            n_n2[a] = NW'(hs) - NW'(lo);
            n_tag5[a].zero  = (w_loc[1][a] == '0);
            n_tag5[a].above = (lo > hs);
            n_tag5[a].below = (lo < -hs);
            n_tag5[a].neg1  = 1'b0;
            n_tag5[a].neg2  = 1'b0;
        end
    end

    always_comb begin
        logic [NW-1:0]   a1;
        logic [NW-1:0]   a2;
        logic [LOCW-1:0] ad;
        for (int a = 0; a < 3; a++) begin
            a1 = r_n1[a][NW-1] ? -r_n1[a] : r_n1[a];
            a2 = r_n2[a][NW-1] ? -r_n2[a] : r_n2[a];
            ad = r_d5[a][LOCW-1] ? -r_d5[a] : r_d5[a];
            n_dv[a].rem1     = '0;
            n_dv[a].rem2     = '0;
            n_dv[a].q1       = '0;
            n_dv[a].q2       = '0;
            n_dv[a].n1       = {a1[NAW-1:0], {FRAC{1'b0}}};
            n_dv[a].n2       = {a2[NAW-1:0], {FRAC{1'b0}}};
            n_dv[a].d        = ad[DAW-1:0];
            n_dv[a].tag      = r_tag5[a];
            n_dv[a].tag.neg1 = r_n1[a][NW-1] ^ r_d5[a][LOCW-1];
            n_dv[a].tag.neg2 = r_n2[a][NW-1] ^ r_d5[a][LOCW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int a = 0; a < 3; a++) begin
                r_n1[a]   <= n_n1[a];
                r_n2[a]   <= n_n2[a];
                r_d5[a]   <= w_loc[1][a];
                r_tag5[a] <= n_tag5[a];
                r_dv[a]   <= n_dv[a];
            end
        end
    end

    for (genvar a = 0; a < 3; a++) begin : g_axis
        robi_div u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_st  (r_dv[a]),
            .o_st  (w_dq[a])
        );
    end

    always_comb begin
        logic signed [TW-1:0] q1;
        logic signed [TW-1:0] q2;
        for (int a = 0; a < 3; a++) begin
            q1 = $signed(TW'(w_dq[a].q1));
            q2 = $signed(TW'(w_dq[a].q2));
            if (w_dq[a].tag.neg1) begin
                n_t1[a] = -q1 - ((w_dq[a].rem1 != '0) ? TW'(1) : TW'(0));
            end else begin
                n_t1[a] = q1;
            end
            if (w_dq[a].tag.neg2) begin
                n_t2[a] = -q2 - ((w_dq[a].rem2 != '0) ? TW'(1) : TW'(0));
            end else begin
                n_t2[a] = q2;
            end
        end
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            if (r_tagf[a].zero) begin
                if (r_tagf[a].above) begin
                    n_sm[a] = -T_INF;
                    n_bg[a] = -T_INF;
                end else if (r_tagf[a].below) begin
                    n_sm[a] = T_INF;
                    n_bg[a] = T_INF;
                end else begin
                    n_sm[a] = -T_INF;
                    n_bg[a] = T_INF;
                end
            end else if (r_t1[a] < r_t2[a]) begin
                n_sm[a] = r_t1[a];
                n_bg[a] = r_t2[a];
            end else begin
                n_sm[a] = r_t2[a];
                n_bg[a] = r_t1[a];
            end
        end
    end

    always_comb begin
        n_tmin = r_sm[0];
        n_tmax = r_bg[0];
        for (int a = 1; a < 3; a++) begin
            if (r_sm[a] > n_tmin) begin
                n_tmin = r_sm[a];
            end
            if (r_bg[a] < n_tmax) begin
                n_tmax = r_bg[a];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int a = 0; a < 3; a++) begin
                r_t1[a]   <= n_t1[a];
                r_t2[a]   <= n_t2[a];
                r_tagf[a] <= w_dq[a].tag;
                r_sm[a]   <= n_sm[a];
                r_bg[a]   <= n_bg[a];
            end
            r_tmin <= n_tmin;
            r_tmax <= n_tmax;
        end
    end

    always_comb begin
        w_hit = (r_tmax >= ((r_tmin > TW'(0)) ? r_tmin : TW'(0)));
        if (r_tmin > TE_MAX) begin
            w_entry = TE_MAX[CW-1:0];
        end else if (r_tmin < TE_MIN) begin
            w_entry = TE_MIN[CW-1:0];
        end else begin
            w_entry = r_tmin[CW-1:0];
        end
        w_res = OUT_DW'({w_entry, w_hit});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (w_en) begin
                r_vld <= {r_vld[LAT-2:0], i_s_tvalid};
            end
            if (!r_out_v || i_m_tready) begin
                if (r_skid_v) begin
                    r_out    <= r_skid;
                    r_out_v  <= 1'b1;
                    r_skid_v <= 1'b0;
                end else begin
                    r_out   <= w_res;
                    r_out_v <= r_vld[LAT-1];
                end
            end else if (r_vld[LAT-1] && w_en) begin
                r_skid   <= w_res;
                r_skid_v <= 1'b1;
            end
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out;

endmodule
`default_nettype wire
